// File: rtl/core/efps_pkg.sv
// shared types and constants of the earliest free processor scheduler
// no dependencies; compiled first

package efps_pkg;

   // fixed field widths of the channels and the control register
   localparam int CSR_BITS      = 7;
   localparam int DURATION_BITS = 32;
   localparam int ID_OUT_BITS   = 6;
   localparam int START_BITS    = 48;

   // control from the register block to the sequencer
   typedef struct packed {
      logic                restart;   // register write: reload the table
      logic [CSR_BITS-1:0] count;     // active processors, already clamped
   } cfg_type;

endpackage

// File: rtl/core/efps_if.sv
// valid/ready channel interfaces of the scheduler: job request and assignment
// depends on efps_pkg for the field widths

interface efps_req_if;
   import efps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [DURATION_BITS-1:0] job_duration;

   modport source (output valid, output job_duration, input ready);
   modport sink   (input valid, input job_duration, output ready);
endinterface

interface efps_rsp_if;
   import efps_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ID_OUT_BITS-1:0] processor_id;
   logic [START_BITS-1:0]  start_time;

   modport source (output valid, output processor_id, output start_time, input ready);
   modport sink   (input valid, input processor_id, input start_time, output ready);
endinterface

// File: rtl/core/earliest_free_processor_scheduler.sv
// top level of the earliest free processor scheduler: control register,
// table ram and heap sequencer; depends on efps_pkg, efps_if, efps_ram, efps_sift
//
//  channel | direction | payload                        | transfer when
//  req_if  | in        | job_duration                   | valid && ready
//  rsp_if  | out       | processor_id, start_time       | valid && ready
//  csr_*   | in        | write_data (processor count)   | write_enable
//
// a new job is taken only after the sift-down of the last one, which moves
// one table level per cycle through the ram's registered read ports
// reset and every count write run a clearing pass over all MAX_PROCESSORS entries
// that writes zero time and the own index into each entry; no request is taken
// a pending result stalls the root pop only; the request side is free again
// as soon as the sift has written its last entry

module earliest_free_processor_scheduler #(
   parameter int MAX_PROCESSORS = 64,
   parameter int TIME_BITS      = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   efps_req_if.sink                      req_if,
   efps_rsp_if.source                    rsp_if,
   input  logic                          csr_write_enable,
   input  logic [efps_pkg::CSR_BITS-1:0] csr_write_data
);
   import efps_pkg::*;

   localparam int AW = $clog2(MAX_PROCESSORS);
   localparam int EW = TIME_BITS + AW;

   // active processor count, always within 1 .. min(127, MAX_PROCESSORS)
   logic [CSR_BITS-1:0] count_ff, count_in;
   cfg_type             cfg;

   // table ram hookup
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [EW-1:0] rd_data_a, rd_data_b;

   // clamp the written count: zero acts as one, above the table depth as the depth
   always_comb begin
      count_in = count_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            count_in = CSR_BITS'(1);
         end else if (int'(csr_write_data) > MAX_PROCESSORS) begin
            count_in = CSR_BITS'(MAX_PROCESSORS);
         end else begin
            count_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CSR_BITS'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   // the write itself restarts the table; the new count is in place once
   // the clearing pass ends
   assign cfg.restart = csr_write_enable;
   assign cfg.count   = count_ff;

   // min-heap of {free time, processor index}, root at entry zero
   efps_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_PROCESSORS)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // pop the root, report it, advance its time and sift it back down
   efps_sift #(
      .MAX_PROCESSORS (MAX_PROCESSORS),
      .TIME_BITS      (TIME_BITS)
   ) u_sift (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

// File: rtl/core/efps_ram.sv
// generic single-write, dual-read ram with registered read data
// no dependencies

module efps_ram #(
   parameter int WIDTH = 54,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: rtl/core/efps_sift.sv
// heap sequencer: clearing pass, root pop, sift-down over the table ram
// and the result register; depends on efps_pkg and efps_if

module efps_sift #(
   parameter int MAX_PROCESSORS = 64,
   parameter int TIME_BITS      = 48
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  efps_pkg::cfg_type                              cfg,
   efps_req_if.sink                                       req_if,
   efps_rsp_if.source                                     rsp_if,
   output logic                                           wr_en,
   output logic [$clog2(MAX_PROCESSORS)-1:0]              wr_addr,
   output logic [TIME_BITS+$clog2(MAX_PROCESSORS)-1:0]    wr_data,
   output logic [$clog2(MAX_PROCESSORS)-1:0]              rd_addr_a,
   output logic [$clog2(MAX_PROCESSORS)-1:0]              rd_addr_b,
   input  logic [TIME_BITS+$clog2(MAX_PROCESSORS)-1:0]    rd_data_a,
   input  logic [TIME_BITS+$clog2(MAX_PROCESSORS)-1:0]    rd_data_b
);
   import efps_pkg::*;

   localparam int AW = $clog2(MAX_PROCESSORS);
   localparam int EW = TIME_BITS + AW;
   localparam int IW = (AW + 2 > CSR_BITS + 1) ? AW + 2 : CSR_BITS + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [AW-1:0]        LAST_IDX = AW'(MAX_PROCESSORS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ROOT  = 4'b0100,
      ST_SIFT  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [EW-1:0]          cur_ff, cur_in;
   logic [DURATION_BITS-1:0] dur_ff, dur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_OUT_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [START_BITS-1:0]  rsp_time_ff, rsp_time_in;

   logic                   accept;
   logic                   out_free;
   logic [TIME_BITS:0]     sum;
   logic [TIME_BITS-1:0]   new_time;
   logic [IW-1:0]          left_idx, right_idx, next_left;
   logic                   have_left, have_right;
   logic                   pick_right;
   logic [EW-1:0]          best_key;
   logic [AW-1:0]          best_idx;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // saturating advance of the popped root time
   assign sum      = {1'b0, rd_data_a[EW-1:AW]} + (TIME_BITS+1)'(dur_ff);
   assign new_time = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

   // children of the current position against the active heap size
   assign left_idx   = (IW'(pos_ff) << 1) + IW'(1);
   assign right_idx  = (IW'(pos_ff) << 1) + IW'(2);
   assign have_left  = left_idx < IW'(cfg.count);
   assign have_right = right_idx < IW'(cfg.count);
   assign pick_right = have_right && (rd_data_b < rd_data_a);
   assign best_key   = pick_right ? rd_data_b : rd_data_a;
   assign best_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_time_in  = rsp_time_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{TIME_BITS{1'b0}}, clr_ff};
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               dur_in   = req_if.job_duration;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = ID_OUT_BITS'(rd_data_a[AW-1:0]);
               rsp_time_in  = START_BITS'(rd_data_a[EW-1:AW]);
               cur_in       = {new_time, rd_data_a[AW-1:0]};
               pos_in       = '0;
               state_in     = ST_SIFT;
            end
         end
         ST_SIFT: begin
            wr_en = 1'b1;
            if (have_left && (best_key < cur_ff)) begin
               wr_data = best_key;
               pos_in  = best_idx;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (cfg.restart) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   // reads: root while waiting for it, children of the next position in the sift
   assign next_left = (IW'(pos_in) << 1) + IW'(1);
   assign rd_addr_a = (state_in == ST_SIFT) ? next_left[AW-1:0] : '0;
   assign rd_addr_b = (state_in == ST_SIFT) ? next_left[AW-1:0] + AW'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      dur_ff      <= dur_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.processor_id = rsp_id_ff;
   assign rsp_if.start_time   = rsp_time_ff;

`ifndef SYNTHESIS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      cfg.restart |=> (state_ff == ST_CLEAR))
      else $error("register write did not start the clearing pass");

   a_sift_in_heap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_SIFT)) |-> (IW'(wr_addr) < IW'(cfg.count)))
      else $error("sift wrote outside the active heap");

   a_result_from_root: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ROOT))
      else $error("result raised outside the root pop");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SIFT) || (state_ff == ST_CLEAR)) |-> !req_if.ready)
      else $error("request taken while the table is busy");
`endif

endmodule

// File: sim/tb_earliest_free_processor_scheduler.sv
// self-checking testbench of the earliest free processor scheduler
// depends on efps_pkg, efps_if and the scheduler rtl; runs stand-alone
`timescale 1ns / 100ps

module tb_earliest_free_processor_scheduler;
   import efps_pkg::*;

   localparam int MAX_PROCS   = 64;
   localparam int TIME_W      = 48;
   localparam int SETTLE      = 24;         // sift of the last job plus margin
   localparam int CYCLE_LIMIT = 200_000;    // several times the slowest clean run
   localparam int PRINT_CAP   = 50;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [DURATION_BITS-1:0] DURATION_MAX = {DURATION_BITS{1'b1}};

   // one job assignment as the result channel carries it
   typedef struct packed {
      logic [ID_OUT_BITS-1:0] processor_id;
      logic [START_BITS-1:0]  start_time;
   } assignment_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_BITS-1:0] csr_write_data;

   efps_req_if req_bus ();
   efps_rsp_if rsp_bus ();

   // predicted table of processor free times and the active count
   logic [TIME_W-1:0] free_times [0:MAX_PROCS-1];
   int                active_count;
   assignment_type    pending_assignments [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_results = 1'b0;

   earliest_free_processor_scheduler #(
      .MAX_PROCESSORS(MAX_PROCS),
      .TIME_BITS(TIME_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // 10 ns clock, rising edges at 5, 15, ...
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_earliest_free_processor_scheduler: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t ns: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // a count write reloads the table; 0 acts as 1, above the depth as the depth
   task automatic load_processor_count(input logic [CSR_BITS-1:0] value);
      if (value == '0)
         active_count = 1;
      else if (int'(value) > MAX_PROCS)
         active_count = MAX_PROCS;
      else
         active_count = int'(value);
      for (int i = 0; i < MAX_PROCS; i++)
         free_times[i] = '0;
   endtask

   // earliest free processor, lowest index on a tie; free time saturates
   task automatic predict_assignment(input logic [DURATION_BITS-1:0] duration);
      int              best;
      logic [TIME_W:0] sum;
      assignment_type  a;
      best = 0;
      for (int i = 1; i < active_count; i++)
         if (free_times[i] < free_times[best])
            best = i;
      a.processor_id = best[ID_OUT_BITS-1:0];
      a.start_time   = free_times[best];
      sum = {1'b0, free_times[best]} + (TIME_W+1)'(duration);
      free_times[best] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
      pending_assignments = {pending_assignments, a};
   endtask

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // result side: random stalls, or a long hold-off while hold_results is set
   always @(negedge clock) begin
      rsp_bus.ready = !hold_results && ($urandom_range(99) >= recv_stall_pct);
   end

   // one job request; called at a falling edge, returns at a falling edge
   // valid stays high on return so back-to-back jobs need no gap
   task automatic send_job(input logic [DURATION_BITS-1:0] duration);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.job_duration = duration;
      do
         @(posedge clock);
      while (!req_bus.ready);
      // transfer taken at this edge
      predict_assignment(duration);
      @(negedge clock);
   endtask

   // lower the request, wait for every result, then let the last sift finish
   task automatic settle_block();
      req_bus.valid = 1'b0;
      while (pending_assignments.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // count register write, only with the block idle
   task automatic write_processor_count(input logic [CSR_BITS-1:0] value);
      settle_block();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      load_processor_count(value);
   endtask

   // mix of zero, tiny (ties), medium and full-range durations
   function automatic logic [DURATION_BITS-1:0] random_duration();
      case ($urandom_range(3))
         0:       return '0;
         1:       return $urandom_range(15);
         2:       return $urandom_range(100_000);
         default: return $urandom();
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result checker: every transfer against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      assignment_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_assignments.size() == 0) begin
            report_mismatch($sformatf("unexpected result id %0d start %0h",
                                      rsp_bus.processor_id, rsp_bus.start_time));
         end else begin
            want = pending_assignments.pop_front();
            if (rsp_bus.processor_id !== want.processor_id)
               report_mismatch($sformatf("processor_id got %0d expected %0d",
                                         rsp_bus.processor_id, want.processor_id));
            if (rsp_bus.start_time !== want.start_time)
               report_mismatch($sformatf("start_time got %0h expected %0h",
                                         rsp_bus.start_time, want.start_time));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset count of one: every job lands on processor 0, times accumulate
   task automatic test_reset_state();
      send_job('0);
      send_job(1);
      send_job(DURATION_MAX);
      send_job('0);
      send_job(32'h8000_0001);
   endtask

   // zero acts as one, values above the depth act as the depth
   task automatic test_count_clamp();
      write_processor_count('0);
      send_job(5);
      send_job(5);
      send_job('0);
      write_processor_count({CSR_BITS{1'b1}});
      send_job(DURATION_MAX);
      send_job(3);
      send_job(3);
      write_processor_count(CSR_BITS'(MAX_PROCS + 1));
      send_job(9);
      send_job(9);
   endtask

   // equal free times go to the lowest index; zero duration keeps the tie
   task automatic test_tie_break();
      write_processor_count(CSR_BITS'(4));
      for (int i = 0; i < 4; i++)
         send_job(10);
      send_job(3);
      send_job('0);
      send_job(7);
      send_job('0);
      send_job(1);
   endtask

   // one processor, full durations carry its free time well past 32 bits
   task automatic test_long_durations();
      write_processor_count(CSR_BITS'(1));
      for (int i = 0; i < 40; i++)
         send_job(DURATION_MAX);
      send_job('0);
      send_job(1);
      // a count write starts from zero again
      write_processor_count(CSR_BITS'(2));
      send_job(DURATION_MAX);
      send_job(DURATION_MAX);
      send_job(1);
   endtask

   // random durations under one idling and stalling pattern and one count
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [CSR_BITS-1:0] count, input int items);
      write_processor_count(count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < items; i++)
         send_job(random_duration());
      settle_block();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // result side held off for a long stretch while requests keep coming
   task automatic test_result_backpressure();
      write_processor_count(CSR_BITS'($urandom_range(2, 16)));
      fork
         begin
            hold_results = 1'b1;
            repeat (400) @(negedge clock);
            hold_results = 1'b0;
         end
         for (int i = 0; i < 60; i++)
            send_job(random_duration());
      join
      settle_block();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid        = 1'b0;
      req_bus.job_duration = '0;
      rsp_bus.ready        = 1'b0;
      load_processor_count(CSR_BITS'(1));
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_count_clamp();
      test_tie_break();
      test_long_durations();
      test_random_traffic(0, 0, CSR_BITS'(MAX_PROCS), 400);
      test_random_traffic(67, 0, CSR_BITS'($urandom_range(2, MAX_PROCS - 1)), 400);
      test_random_traffic(0, 67, CSR_BITS'($urandom_range(MAX_PROCS + 1, 127)), 400);
      test_random_traffic(11, 11, CSR_BITS'($urandom_range(1, MAX_PROCS)), 400);
      test_result_backpressure();

      settle_block();
      if (pending_assignments.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_assignments.size()));
      if (error_count == 0)
         $display("tb_earliest_free_processor_scheduler: done, clean");
      else
         $display("tb_earliest_free_processor_scheduler: done, errors");
      $finish;
   end

endmodule
